// File: sv/tsos_pkg.sv
// Package of the two-satisfiability opinion solver.
// Holds the sequencer state type, the fixed field widths and the parameter defaults.
// No dependencies.
package tsos_pkg;

  localparam int FIELD_W         = 7;
  localparam int CODE_W          = FIELD_W + 1;
  localparam int CLAUSE_W        = 2 * CODE_W;
  localparam int S_DATA_W        = 32;
  localparam int M_DATA_W        = 8;
  localparam int MAX_VARS_DEF    = 64;
  localparam int MAX_CLAUSES_DEF = 256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD2,
    ST_P1_NEXT,
    ST_SCAN,
    ST_EVAL,
    ST_POP,
    ST_POP_WAIT,
    ST_P2_NEXT,
    ST_P2_WAIT,
    ST_CHK,
    ST_CHK_A,
    ST_CHK_B,
    ST_DONE
  } state_e;

endpackage

// File: sv/two_sat_opinion_solver.sv
// Two-satisfiability opinion solver: stores clauses, then runs Kosaraju's search.
// Depends on tsos_pkg, tsos_ram and tsos_edge_unit.
// An opinion with two clauses stores its second one in a further state, ST_LOAD2.
// The solve after a last item runs two depth-first passes and then the check; the
// clause RAM is read for each edge that the depth-first search scans. Items are
// taken one at a time: the input is not ready until a solve or a second clause is done.
// Reset (asynchronous, active low) empties the store, clears the overflow flag and
// sets num_proposals to 1; no clearing pass is needed.
module two_sat_opinion_solver import tsos_pkg::*; #(
  parameter int MAX_VARS    = MAX_VARS_DEF,
  parameter int MAX_CLAUSES = MAX_CLAUSES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: num_proposals.
  input  logic                cfg_we_i,
  input  logic [FIELD_W-1:0]  cfg_wdata_i,
  // Input: keep_first[6:0], keep_second[13:7], drop_first[20:14], drop_second[27:21].
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  input  logic                s_axis_tlast_i,
  // Output: satisfiable[0], overflow[1].
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o
);

  // Vertex index, counters that can hold the vertex count, clause and edge widths.
  localparam int NV   = 2 * MAX_VARS;
  localparam int VW   = $clog2(NV);
  localparam int DW   = VW + 1;
  localparam int NW   = $clog2(MAX_VARS + 1);
  localparam int KW   = (NW > FIELD_W) ? NW : FIELD_W;
  localparam int AW   = $clog2(MAX_CLAUSES);
  localparam int CCW  = $clog2(MAX_CLAUSES + 1);
  localparam int EW   = CCW + 1;
  localparam int SW   = VW + EW;

  state_e state_q, state_d;

  logic [FIELD_W-1:0]  nprop_q;
  logic [KW-1:0]       n_eff;
  logic [DW-1:0]       nodes;
  logic [EW-1:0]       edges;

  logic [CCW-1:0]      count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [CLAUSE_W-1:0] pend_q, pend_d;
  logic                last_q, last_d;
  logic [NV-1:0]       visited_q, visited_d;
  logic [DW-1:0]       vidx_q, vidx_d;
  logic [DW-1:0]       fin_q, fin_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic [VW-1:0]       top_v_q, top_v_d;
  logic [EW-1:0]       top_e_q, top_e_d;
  logic                rev_q, rev_d;
  logic [DW-1:0]       comp_q, comp_d;
  logic [DW-1:0]       cid_a_q, cid_a_d;
  logic                sat_q, sat_d;
  logic                m_valid_q, m_valid_d;
  logic [1:0]          m_data_q, m_data_d;

  // Opinion decode.
  logic [FIELD_W-1:0]  k1, k2, d1, d2, kk1, kk2, dd1, dd2;
  logic [CLAUSE_W-1:0] k_clause, d_clause;
  logic                has_k, has_d, add_req, start_solve;

  // Memories.
  logic                cl_we;
  logic [CLAUSE_W-1:0] cl_wdata, cl_rdata;
  logic                st_we;
  logic [SW-1:0]       st_wdata, st_rdata;
  logic [DW-1:0]       st_wptr, st_rptr, fin_rptr;
  logic                fin_we;
  logic [VW-1:0]       fin_rdata;
  logic                cid_we;
  logic [VW-1:0]       cid_raddr;
  logic [DW-1:0]       cid_rdata;

  // Edge unit outputs.
  logic                e_ok;
  logic [VW-1:0]       e_from, e_to;

  always_comb begin
    if (KW'(nprop_q) > KW'(MAX_VARS)) begin
      n_eff = KW'(MAX_VARS);
    end else begin
      n_eff = KW'(nprop_q);
    end
    nodes = DW'({n_eff, 1'b0});
    edges = {count_q, 1'b0};
  end

  always_comb begin
    k1  = s_axis_tdata_i[FIELD_W-1:0];
    k2  = s_axis_tdata_i[2*FIELD_W-1:FIELD_W];
    d1  = s_axis_tdata_i[3*FIELD_W-1:2*FIELD_W];
    d2  = s_axis_tdata_i[4*FIELD_W-1:3*FIELD_W];
    // A single zero in a pair takes its partner's value.
    kk1 = (k1 == '0) ? k2 : k1;
    kk2 = (k2 == '0) ? kk1 : k2;
    dd1 = (d1 == '0) ? d2 : d1;
    dd2 = (d2 == '0) ? dd1 : d2;
    has_k    = (kk1 != '0);
    has_d    = (dd1 != '0);
    // Literal code is proposal shifted up with the positive flag in bit zero.
    k_clause = {kk2, 1'b1, kk1, 1'b1};
    d_clause = {dd2, 1'b0, dd1, 1'b0};
  end

  tsos_ram #(.WIDTH(CLAUSE_W), .DEPTH(MAX_CLAUSES)) u_clause_ram (
    .clk_i   (clk_i),
    .we_i    (cl_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (cl_wdata),
    .raddr_i (top_e_q[AW:1]),
    .rdata_o (cl_rdata)
  );

  assign st_wptr  = depth_q - DW'(1);
  assign st_rptr  = depth_q - DW'(2);
  assign st_wdata = {top_v_q, top_e_q + EW'(1)};

  tsos_ram #(.WIDTH(SW), .DEPTH(NV)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_wptr[VW-1:0]),
    .wdata_i (st_wdata),
    .raddr_i (st_rptr[VW-1:0]),
    .rdata_o (st_rdata)
  );

  assign fin_rptr = fin_q - DW'(1);

  tsos_ram #(.WIDTH(VW), .DEPTH(NV)) u_finish_ram (
    .clk_i   (clk_i),
    .we_i    (fin_we),
    .waddr_i (fin_q[VW-1:0]),
    .wdata_i (top_v_q),
    .raddr_i (fin_rptr[VW-1:0]),
    .rdata_o (fin_rdata)
  );

  assign cid_raddr = (state_q == ST_CHK_A) ? (vidx_q[VW-1:0] | VW'(1)) : vidx_q[VW-1:0];

  tsos_ram #(.WIDTH(DW), .DEPTH(NV)) u_comp_ram (
    .clk_i   (clk_i),
    .we_i    (cid_we),
    .waddr_i (top_v_q),
    .wdata_i (comp_q),
    .raddr_i (cid_raddr),
    .rdata_o (cid_rdata)
  );

  tsos_edge_unit #(.MAX_VARS(MAX_VARS)) u_edge (
    .clause_i (cl_rdata),
    .odd_i    (top_e_q[0]),
    .rev_i    (rev_q),
    .n_eff_i  (n_eff),
    .ok_o     (e_ok),
    .from_o   (e_from),
    .to_o     (e_to)
  );

  // Sequencer: loading, the two search passes sharing one depth-first walker, and the
  // final check of each proposal against its negation.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    pend_d      = pend_q;
    last_d      = last_q;
    visited_d   = visited_q;
    vidx_d      = vidx_q;
    fin_d       = fin_q;
    depth_d     = depth_q;
    top_v_d     = top_v_q;
    top_e_d     = top_e_q;
    rev_d       = rev_q;
    comp_d      = comp_q;
    cid_a_d     = cid_a_q;
    sat_d       = sat_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    cl_we       = 1'b0;
    cl_wdata    = k_clause;
    add_req     = 1'b0;
    start_solve = 1'b0;
    st_we       = 1'b0;
    fin_we      = 1'b0;
    cid_we      = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (has_k) begin
            add_req = 1'b1;
            if (has_d) begin
              pend_d  = d_clause;
              last_d  = s_axis_tlast_i;
              state_d = ST_LOAD2;
            end else begin
              start_solve = s_axis_tlast_i;
            end
          end else begin
            add_req     = has_d;
            cl_wdata    = d_clause;
            start_solve = s_axis_tlast_i;
          end
        end
      end
      ST_LOAD2: begin
        add_req     = 1'b1;
        cl_wdata    = pend_q;
        start_solve = last_q;
        state_d     = ST_IDLE;
      end
      ST_P1_NEXT: begin
        if (vidx_q == nodes) begin
          visited_d = '0;
          rev_d     = 1'b1;
          comp_d    = DW'(1);
          state_d   = ST_P2_NEXT;
        end else if (!visited_q[vidx_q[VW-1:0]]) begin
          visited_d[vidx_q[VW-1:0]] = 1'b1;
          top_v_d = vidx_q[VW-1:0];
          top_e_d = '0;
          depth_d = DW'(1);
          state_d = ST_SCAN;
        end else begin
          vidx_d = vidx_q + DW'(1);
        end
      end
      ST_SCAN: begin
        // The clause of the current edge is read here and decoded in the next cycle.
        if (top_e_q == edges) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (e_ok && (e_from == top_v_q) && !visited_q[e_to]) begin
          st_we   = 1'b1;
          visited_d[e_to] = 1'b1;
          top_v_d = e_to;
          top_e_d = '0;
          depth_d = depth_q + DW'(1);
        end else begin
          top_e_d = top_e_q + EW'(1);
        end
        state_d = ST_SCAN;
      end
      ST_POP: begin
        if (rev_q) begin
          cid_we = 1'b1;
        end else begin
          fin_we = 1'b1;
          fin_d  = fin_q + DW'(1);
        end
        depth_d = depth_q - DW'(1);
        if (depth_q == DW'(1)) begin
          if (rev_q) begin
            comp_d  = comp_q + DW'(1);
            state_d = ST_P2_NEXT;
          end else begin
            state_d = ST_P1_NEXT;
          end
        end else begin
          state_d = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        top_v_d = st_rdata[SW-1:EW];
        top_e_d = st_rdata[EW-1:0];
        state_d = ST_SCAN;
      end
      ST_P2_NEXT: begin
        if (fin_q == '0) begin
          vidx_d  = '0;
          state_d = ST_CHK;
        end else begin
          fin_d   = fin_q - DW'(1);
          state_d = ST_P2_WAIT;
        end
      end
      ST_P2_WAIT: begin
        if (!visited_q[fin_rdata]) begin
          visited_d[fin_rdata] = 1'b1;
          top_v_d = fin_rdata;
          top_e_d = '0;
          depth_d = DW'(1);
          state_d = ST_SCAN;
        end else begin
          state_d = ST_P2_NEXT;
        end
      end
      ST_CHK: begin
        if (vidx_q == nodes) begin
          sat_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CHK_A;
        end
      end
      ST_CHK_A: begin
        cid_a_d = cid_rdata;
        state_d = ST_CHK_B;
      end
      ST_CHK_B: begin
        if (cid_rdata == cid_a_q) begin
          sat_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          vidx_d  = vidx_q + DW'(2);
          state_d = ST_CHK;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {ovf_q, sat_q};
          count_d   = '0;
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A clause that does not fit is dropped and remembered as overflow.
    if (add_req) begin
      if (count_q < CCW'(MAX_CLAUSES)) begin
        cl_we   = 1'b1;
        count_d = count_q + CCW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (start_solve) begin
      visited_d = '0;
      vidx_d    = '0;
      fin_d     = '0;
      rev_d     = 1'b0;
      state_d   = ST_P1_NEXT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      nprop_q   <= FIELD_W'(1);
      count_q   <= '0;
      ovf_q     <= 1'b0;
      visited_q <= '0;
      m_valid_q <= 1'b0;
      last_q    <= 1'b0;
      rev_q     <= 1'b0;
      vidx_q    <= '0;
      fin_q     <= '0;
      depth_q   <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        nprop_q <= cfg_wdata_i;
      end
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      visited_q <= visited_d;
      m_valid_q <= m_valid_d;
      last_q    <= last_d;
      rev_q     <= rev_d;
      vidx_q    <= vidx_d;
      fin_q     <= fin_d;
      depth_q   <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    top_v_q  <= top_v_d;
    top_e_q  <= top_e_d;
    comp_q   <= comp_d;
    cid_a_q  <= cid_a_d;
    sat_q    <= sat_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_DATA_W - 2){1'b0}}, m_data_q};

  // The clause count never passes the store size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CCW'(MAX_CLAUSES))
    else $error("clause count beyond capacity");

  // The search stack and the finish stack never hold more than all vertices.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q <= DW'(NV)) && (fin_q <= DW'(NV)))
    else $error("search or finish stack beyond vertex count");

  // A result appears only when the sequencer finishes a solve.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside of solve completion");

endmodule

// File: sv/tsos_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tsos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tsos_edge_unit.sv
// Edge decoder: turns one stored clause and an edge selector into an implication edge.
// Depends on tsos_pkg.
module tsos_edge_unit import tsos_pkg::*; #(
  parameter int MAX_VARS = MAX_VARS_DEF,
  parameter int VW       = $clog2(2 * MAX_VARS),
  parameter int NW       = $clog2(MAX_VARS + 1),
  parameter int KW       = (NW > FIELD_W) ? NW : FIELD_W
) (
  input  logic [CLAUSE_W-1:0] clause_i,
  input  logic                odd_i,
  input  logic                rev_i,
  input  logic [KW-1:0]       n_eff_i,
  output logic                ok_o,
  output logic [VW-1:0]       from_o,
  output logic [VW-1:0]       to_o
);

  localparam int LW = (VW > CODE_W) ? VW : CODE_W;

  logic [FIELD_W-1:0] a_var, b_var;
  logic [LW-1:0]      a_full, b_full;
  logic [VW-1:0]      va, vb, f, t;
  logic               a_ok, b_ok;

  always_comb begin
    a_var  = clause_i[CODE_W-1:1];
    b_var  = clause_i[CLAUSE_W-1:CODE_W+1];
    a_ok   = (a_var != '0) && (KW'(a_var) <= n_eff_i);
    b_ok   = (b_var != '0) && (KW'(b_var) <= n_eff_i);
    a_full = LW'({a_var - FIELD_W'(1), clause_i[0]});
    b_full = LW'({b_var - FIELD_W'(1), clause_i[CODE_W]});
    va     = a_full[VW-1:0];
    vb     = b_full[VW-1:0];
    // Clause (a or b) gives not a -> b and not b -> a.
    if (!odd_i) begin
      f = va ^ VW'(1);
      t = vb;
    end else begin
      f = vb ^ VW'(1);
      t = va;
    end
    ok_o   = a_ok && b_ok;
    from_o = rev_i ? t : f;
    to_o   = rev_i ? f : t;
  end

endmodule
